### src/sldb_pkg.sv
// Shared constants and types for the stereo level direction bar writer.
`timescale 1ns / 1ps

package sldb_pkg;

	// Field widths
	localparam int LevelW  = 10;
	localparam int ThreshW = 11;
	localparam int ColW    = 5;
	localparam int ByteW   = 8;
	localparam int RowW    = 4;

	// Display geometry
	localparam logic [ByteW-1:0] Cols        = 8'd30;
	localparam logic [ColW-1:0]  LeftBase    = 5'd15;
	localparam logic [ColW-1:0]  RightBase   = 5'd14;
	localparam logic [ColW-1:0]  LowOffset   = 5'd14;
	localparam logic [ColW-1:0]  LowWrap     = 5'd16;
	localparam logic [ColW-1:0]  UpExtraMax  = 5'd15;
	localparam logic [ColW-1:0]  LoExtraMax  = 5'd13;
	localparam logic [RowW-1:0]  UpRowsBase  = 4'd8;
	localparam logic [RowW-1:0]  LoRowsBase  = 4'd4;
	localparam logic [3:0]       HalfCap     = 4'd15;
	localparam logic [LevelW-1:0] MinDiff    = 10'd2;

	// Display register addresses and data
	localparam logic [ByteW-1:0] AddrNone = 8'h00;
	localparam logic [ByteW-1:0] AddrHalf = 8'h05;
	localparam logic [ByteW-1:0] AddrCell = 8'h06;
	localparam logic [ByteW-1:0] AddrData = 8'h07;
	localparam logic [ByteW-1:0] BarByte  = 8'hFF;
	localparam logic [ByteW-1:0] HalfUp   = 8'h00;
	localparam logic [ByteW-1:0] HalfLo   = 8'h01;

	// Decoded request handed from decode to sequencer
	typedef struct packed {
		logic            found;
		logic [ColW-1:0] col;
		logic [ColW-1:0] low;
		logic            up_extra;
		logic            lo_extra;
	} dec_t;

endpackage

### src/sldb_decode.sv
// Input register stage: threshold register and column decode of a level pair.
`timescale 1ns / 1ps

module sldb_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          detect_threshold_we,
	input  logic [sldb_pkg::ThreshW-1:0]  detect_threshold,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sldb_pkg::LevelW-1:0]   left_level,
	input  logic [sldb_pkg::LevelW-1:0]   right_level,
	output logic                          dec_valid,
	input  logic                          dec_ready,
	output sldb_pkg::dec_t                dec
);
	import sldb_pkg::*;

	logic [ThreshW-1:0] thresh_q;
	logic               valid_s1;
	dec_t               dec_s1;

	logic              left;
	logic [LevelW-1:0] hi;
	logic [LevelW-1:0] lo;
	logic [LevelW-1:0] diff;
	logic [LevelW-1:0] diff_m1;
	logic [LevelW-2:0] half_raw;
	logic [3:0]        half;
	dec_t              dec_d;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 11'd15;
		end else if (detect_threshold_we) begin
			thresh_q <= detect_threshold;
		end
	end

	// Louder side, margin in steps of two, column and lower start
	always_comb begin
		left     = left_level > right_level;
		hi       = left ? left_level : right_level;
		lo       = left ? right_level : left_level;
		diff     = hi - lo;
		diff_m1  = diff - 10'd1;
		half_raw = diff_m1[LevelW-1:1];
		half     = (half_raw > {5'd0, HalfCap}) ? HalfCap : half_raw[3:0];
		dec_d.found    = ({1'b0, hi} > thresh_q) && (diff > MinDiff);
		dec_d.col      = left ? (LeftBase - {1'b0, half}) : (RightBase + {1'b0, half});
		dec_d.low      = (dec_d.col >= LowWrap) ? (dec_d.col - LowWrap)
		                                        : (dec_d.col + LowOffset);
		dec_d.up_extra = dec_d.col <= UpExtraMax;
		dec_d.lo_extra = dec_d.low <= LoExtraMax;
	end

	assign in_ready = !valid_s1 || dec_ready;

	// Decoded request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dec_s1 <= dec_d;
		end
	end

	assign dec_valid = valid_s1;
	assign dec       = dec_s1;

endmodule

### src/sldb_seq.sv
// Write sequencer: walks the bar register writes into the output register.
`timescale 1ns / 1ps

module sldb_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dec_valid,
	output logic                        dec_ready,
	input  sldb_pkg::dec_t              dec,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        sound_found,
	output logic [sldb_pkg::ByteW-1:0]  reg_addr,
	output logic [sldb_pkg::ByteW-1:0]  reg_data,
	output logic [sldb_pkg::ColW-1:0]   bar_column,
	output logic                        last
);
	import sldb_pkg::*;

	typedef enum logic [2:0] {
		PH_NONE,
		PH_HALF_UP,
		PH_UP_CELL,
		PH_UP_DATA,
		PH_HALF_LO,
		PH_LO_CELL,
		PH_LO_DATA
	} phase_t;

	logic              busy_q;
	phase_t            phase_q;
	logic [RowW-1:0]   row_q;
	logic [ByteW-1:0]  cell_q;
	dec_t              item_q;
	logic              out_valid_q;
	logic              found_q;
	logic [ByteW-1:0]  addr_q;
	logic [ByteW-1:0]  data_q;
	logic [ColW-1:0]   col_q;
	logic              last_q;

	logic              adv;
	logic              take;
	logic              step_last;
	logic [RowW-1:0]   up_last_row;
	logic [RowW-1:0]   lo_last_row;
	phase_t            phase_d;
	logic [RowW-1:0]   row_d;
	logic [ByteW-1:0]  cell_d;
	logic              found_d;
	logic [ByteW-1:0]  addr_d;
	logic [ByteW-1:0]  data_d;

	assign adv         = busy_q && (!out_valid_q || out_ready);
	assign up_last_row = UpRowsBase - (item_q.up_extra ? 4'd0 : 4'd1);
	assign lo_last_row = LoRowsBase - (item_q.lo_extra ? 4'd0 : 4'd1);
	assign step_last   = (phase_q == PH_NONE) ||
	                     ((phase_q == PH_LO_DATA) && (row_q == lo_last_row));
	assign take        = dec_valid && (!busy_q || (adv && step_last));
	assign dec_ready   = take;

	// Current write and next step
	always_comb begin
		phase_d = phase_q;
		row_d   = row_q;
		cell_d  = cell_q;
		found_d = 1'b1;
		addr_d  = AddrNone;
		data_d  = 8'h00;
		case (phase_q)
			PH_NONE: begin
				found_d = 1'b0;
			end
			PH_HALF_UP: begin
				addr_d  = AddrHalf;
				data_d  = HalfUp;
				row_d   = '0;
				cell_d  = {3'd0, item_q.col};
				phase_d = PH_UP_CELL;
			end
			PH_UP_CELL: begin
				addr_d  = AddrCell;
				data_d  = cell_q;
				phase_d = PH_UP_DATA;
			end
			PH_UP_DATA: begin
				addr_d = AddrData;
				data_d = BarByte;
				if (row_q == up_last_row) begin
					phase_d = PH_HALF_LO;
				end else begin
					row_d   = row_q + 4'd1;
					cell_d  = cell_q + Cols;
					phase_d = PH_UP_CELL;
				end
			end
			PH_HALF_LO: begin
				addr_d  = AddrHalf;
				data_d  = HalfLo;
				row_d   = '0;
				cell_d  = {3'd0, item_q.low};
				phase_d = PH_LO_CELL;
			end
			PH_LO_CELL: begin
				addr_d  = AddrCell;
				data_d  = cell_q;
				phase_d = PH_LO_DATA;
			end
			PH_LO_DATA: begin
				addr_d  = AddrData;
				data_d  = BarByte;
				row_d   = row_q + 4'd1;
				cell_d  = cell_q + Cols;
				phase_d = PH_LO_CELL;
			end
			default: begin
				phase_d = PH_NONE;
			end
		endcase
	end

	// Sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_NONE;
			row_q       <= '0;
			cell_q      <= '0;
			item_q      <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			addr_q      <= '0;
			data_q      <= '0;
			col_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				found_q     <= found_d;
				addr_q      <= addr_d;
				data_q      <= data_d;
				col_q       <= found_d ? item_q.col : 5'd0;
				last_q      <= step_last;
				row_q       <= row_d;
				cell_q      <= cell_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// a new request starts its walk, otherwise step the current one
			if (take) begin
				busy_q  <= 1'b1;
				item_q  <= dec;
				phase_q <= dec.found ? PH_HALF_UP : PH_NONE;
			end else if (adv) begin
				phase_q <= phase_d;
				if (step_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign sound_found = found_q;
	assign reg_addr    = addr_q;
	assign reg_data    = data_q;
	assign bar_column  = col_q;
	assign last        = last_q;

endmodule

### src/stereo_level_direction_bar_writer.sv
// Top level of the stereo level direction bar writer.
// Each accepted left/right level pair yields either one no-sound marker or
// 26 to 30 display register writes (half select, then cell address and data
// pairs), one write per cycle while out_ready is high; the sequencer that
// walks these writes sets the rate. The next pair is decoded and held in the
// input register while the current bar is still being written, and the
// sequencer takes it at the same clock edge that registers the previous
// pair's last write.
`timescale 1ns / 1ps

module stereo_level_direction_bar_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          detect_threshold_we,
	input  logic [sldb_pkg::ThreshW-1:0]  detect_threshold,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sldb_pkg::LevelW-1:0]   left_level,
	input  logic [sldb_pkg::LevelW-1:0]   right_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          sound_found,
	output logic [sldb_pkg::ByteW-1:0]    reg_addr,
	output logic [sldb_pkg::ByteW-1:0]    reg_data,
	output logic [sldb_pkg::ColW-1:0]     bar_column,
	output logic                          last
);
	import sldb_pkg::*;

	logic dec_valid;
	logic dec_ready;
	dec_t dec;

	sldb_decode u_decode (
		.clk                 (clk),
		.arst_n              (arst_n),
		.detect_threshold_we (detect_threshold_we),
		.detect_threshold    (detect_threshold),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.left_level          (left_level),
		.right_level         (right_level),
		.dec_valid           (dec_valid),
		.dec_ready           (dec_ready),
		.dec                 (dec)
	);

	sldb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.dec_valid   (dec_valid),
		.dec_ready   (dec_ready),
		.dec         (dec),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sound_found (sound_found),
		.reg_addr    (reg_addr),
		.reg_data    (reg_data),
		.bar_column  (bar_column),
		.last        (last)
	);

endmodule

### tb/tb.sv
// Self-checking testbench for the stereo level direction bar writer.
`timescale 1ns / 1ps

module tb;
	import sldb_pkg::*;

	localparam int CycleLimit = 600000;
	localparam int HoldCycles = 400;
	localparam int MaxGap     = 18;
	localparam int SettleCyc  = 6;
	localparam int MaxLevel   = 1023;
	localparam int ThreshMax  = 1038;
	localparam int ResetThr   = 15;

	// One display write as seen on the result channel
	typedef struct packed {
		logic             found;
		logic [ByteW-1:0] addr;
		logic [ByteW-1:0] data;
		logic [ColW-1:0]  col;
		logic             last_flag;
	} bar_write_t;

	// Scoreboard: predicts the bar writes for each request and checks them in order
	class bar_scoreboard;
		bar_write_t write_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return write_q.size();
		endfunction

		function void push_write(logic [ByteW-1:0] addr, logic [ByteW-1:0] data, int col);
			bar_write_t w;
			w.found     = 1'b1;
			w.addr      = addr;
			w.data      = data;
			w.col       = col[ColW-1:0];
			w.last_flag = 1'b0;
			write_q.push_back(w);
		endfunction

		// Work out the writes caused by one accepted level pair
		function void note_levels(logic [LevelW-1:0] l, logic [LevelW-1:0] r,
				logic [ThreshW-1:0] thr);
			bar_write_t idle_w;
			bit left_side;
			int hi, lo, margin, col, low_start, k;
			left_side = (l > r);
			hi = left_side ? int'(l) : int'(r);
			lo = left_side ? int'(r) : int'(l);
			// no sound: quiet, or levels too close to tell apart
			if (hi <= int'(thr) || hi - lo <= 2) begin
				idle_w = '0;
				idle_w.last_flag = 1'b1;
				write_q.push_back(idle_w);
				return;
			end
			margin = ((hi - lo - 1) / 2) * 2;
			if (margin > 30)
				margin = 30;
			col = left_side ? (15 - margin / 2) : (14 + margin / 2);
			low_start = (col + 14) % 30;
			// upper half
			push_write(AddrHalf, HalfUp, col);
			for (k = 0; k < 8; k++) begin
				push_write(AddrCell, ByteW'(col + 30 * k), col);
				push_write(AddrData, BarByte, col);
			end
			if (col <= 15) begin
				push_write(AddrCell, ByteW'(col + 240), col);
				push_write(AddrData, BarByte, col);
			end
			// lower half
			push_write(AddrHalf, HalfLo, col);
			for (k = 0; k < 4; k++) begin
				push_write(AddrCell, ByteW'(low_start + 30 * k), col);
				push_write(AddrData, BarByte, col);
			end
			if (low_start <= 13) begin
				push_write(AddrCell, ByteW'(low_start + 120), col);
				push_write(AddrData, BarByte, col);
			end
			write_q[write_q.size() - 1].last_flag = 1'b1;
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one accepted write with the oldest prediction
		task check_write(bar_write_t got);
			bar_write_t want;
			if (write_q.size() == 0) begin
				report($sformatf("unexpected write addr=%0h data=%0h", got.addr, got.data));
				return;
			end
			want = write_q.pop_front();
			if (got.found !== want.found)
				report($sformatf("sound_found %0b, want %0b", got.found, want.found));
			if (got.addr !== want.addr)
				report($sformatf("reg_addr %0h, want %0h", got.addr, want.addr));
			if (got.data !== want.data)
				report($sformatf("reg_data %0h, want %0h", got.data, want.data));
			if (got.col !== want.col)
				report($sformatf("bar_column %0d, want %0d", got.col, want.col));
			if (got.last_flag !== want.last_flag)
				report($sformatf("last %0b, want %0b", got.last_flag, want.last_flag));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               detect_threshold_we;
	logic [ThreshW-1:0] detect_threshold;
	logic               in_valid;
	logic               in_ready;
	logic [LevelW-1:0]  left_level;
	logic [LevelW-1:0]  right_level;
	logic               out_valid;
	logic               out_ready;
	logic               sound_found;
	logic [ByteW-1:0]   reg_addr;
	logic [ByteW-1:0]   reg_data;
	logic [ColW-1:0]    bar_column;
	logic               last;

	bar_scoreboard sb = new();
	logic [ThreshW-1:0] thr_now;
	bit  send_idle;
	bit  recv_idle;
	int  hold_req;
	int  cycles;

	stereo_level_direction_bar_writer dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.detect_threshold_we (detect_threshold_we),
		.detect_threshold    (detect_threshold),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.left_level          (left_level),
		.right_level         (right_level),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.sound_found         (sound_found),
		.reg_addr            (reg_addr),
		.reg_data            (reg_data),
		.bar_column          (bar_column),
		.last                (last)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_write({sound_found, reg_addr, reg_data, bar_column, last});
	end

	// Receiver: random hold-off per write, plus an occasional long stall on request
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end else begin
				n = recv_idle ? $urandom_range(0, MaxGap) : 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Offer one level pair and return at the edge that accepts it
	task send_levels(logic [LevelW-1:0] l, logic [LevelW-1:0] r);
		int gap;
		gap = send_idle ? $urandom_range(0, MaxGap) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		left_level  <= l;
		right_level <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_levels(l, r, thr_now);
	endtask

	// Drop valid at the accept edge and wait until every predicted write is out
	task drain_writes();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	task set_threshold(int v);
		detect_threshold_we <= 1'b1;
		detect_threshold    <= v[ThreshW-1:0];
		@(posedge clk);
		detect_threshold_we <= 1'b0;
		thr_now = v[ThreshW-1:0];
	endtask

	// Random pairs: mostly a loud side with a small margin, some near-equal, some with any margin, some noise
	task send_random(int count);
		int i, kind, hi, lo, d, floor_lvl;
		for (i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				send_levels(LevelW'($urandom_range(0, MaxLevel)),
				            LevelW'($urandom_range(0, MaxLevel)));
			end else begin
				floor_lvl = (int'(thr_now) < MaxLevel) ? int'(thr_now) + 1 : 0;
				hi = $urandom_range(MaxLevel, floor_lvl);
				if (kind == 2)
					d = $urandom_range(0, 2);
				else if (kind == 3)
					d = $urandom_range(0, MaxLevel);
				else
					d = $urandom_range(0, 40);
				lo = (hi >= d) ? hi - d : 0;
				if ($urandom_range(0, 1))
					send_levels(LevelW'(hi), LevelW'(lo));
				else
					send_levels(LevelW'(lo), LevelW'(hi));
			end
		end
	endtask

	// Main sequence
	initial begin
		arst_n              = 1'b0;
		detect_threshold_we = 1'b0;
		detect_threshold    = '0;
		in_valid            = 1'b0;
		left_level          = '0;
		right_level         = '0;
		thr_now             = ThreshW'(ResetThr);
		send_idle           = 1'b1;
		recv_idle           = 1'b1;
		hold_req            = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at the reset threshold
		send_levels(0, 0);
		send_levels(1023, 1023);
		send_levels(1023, 0);
		send_levels(0, 1023);
		send_levels(15, 0);      // louder side exactly at threshold
		send_levels(16, 0);
		send_levels(16, 13);     // just above threshold, margin 3
		send_levels(18, 16);     // difference of 2
		send_levels(100, 97);
		send_levels(97, 100);
		send_levels(100, 98);
		send_levels(98, 100);
		send_levels(500, 500);
		send_levels(1023, 993);  // margin just under the cap
		send_levels(993, 1023);
		send_levels(1023, 992);  // margin at the cap
		send_levels(992, 1023);
		send_levels(700, 695);
		send_levels(695, 700);
		send_levels(45, 41);     // column 14
		send_levels(41, 45);     // column 15: last with a ninth upper row
		send_levels(40, 45);     // column 16
		drain_writes();

		// zero threshold
		set_threshold(0);
		send_levels(3, 0);
		send_levels(0, 3);
		send_levels(2, 0);
		// long receiver stall while requests keep coming
		hold_req = HoldCycles;
		send_random(30);
		drain_writes();

		// threshold above any level, no idling on either side
		set_threshold(ThreshMax);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_levels(1023, 0);
		send_random(15);
		drain_writes();
		send_idle = 1'b1;
		recv_idle = 1'b1;

		// threshold at full scale
		set_threshold(MaxLevel);
		send_random(10);
		drain_writes();

		// random threshold, with a sender pause until all writes are out
		set_threshold($urandom_range(0, ThreshMax));
		send_random(20);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		send_random(20);
		drain_writes();

		// reset value written back, sender back to back
		set_threshold(ResetThr);
		send_idle = 1'b0;
		send_random(12);
		drain_writes();
		send_idle = 1'b1;

		// just under full scale
		set_threshold(MaxLevel - 1);
		send_levels(1023, 0);
		send_levels(1022, 0);
		send_random(25);
		drain_writes();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
src/sldb_pkg.sv
src/sldb_decode.sv
src/sldb_seq.sv
src/stereo_level_direction_bar_writer.sv
tb/tb.sv
